// File: hw/rtl/pta_pkg.sv
// Shared types and constants for the peer table with aging.
`default_nettype none
package pta_pkg;

  localparam int MAC_W   = 48;
  localparam int POWER_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 20;
  localparam int COUNT_W = 5;

  // table sizes; counts in out_t are sized for these
  localparam int PEER_DEPTH = 16;
  localparam int GONE_DEPTH = 16;
  localparam int MAX_REPORT = 8;

  localparam logic [TOTAL_W-1:0] POWER_MAX = 20'hFFFFF;
  localparam logic [TIME_W-1:0]  STALE_RESET = 32'd6000;

  // register byte addresses
  localparam logic [2:0] ADDR_STALE = 3'd0;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_PURGE  = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_REMOVED = 2'd1;
  localparam logic [1:0] KIND_GONE    = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [MAC_W-1:0]   peer_mac;
    logic [POWER_W-1:0] peer_power;
    logic [PRIO_W-1:0]  peer_priority;
    logic [TIME_W-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [MAC_W-1:0]   entry_mac;
    logic [PRIO_W-1:0]  entry_priority;
    logic [TOTAL_W-1:0] total_power;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] departed_count;
    logic               dropped;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [POWER_W-1:0] power;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  seen;
  } live_ent_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PRIO_W-1:0] prio;
  } gone_ent_t;

endpackage
`default_nettype wire

// File: hw/rtl/peer_table_with_aging_unit.sv
// Top level: peer table with aging, departed list and result sequencer.
//
//   channel   signals                                  direction
//   in        in_valid, in_ready, in_data (in_t)       item in
//   out       out_valid, out_ready, out_data (out_t)   result out
//   cfg       psel, penable, pwrite, paddr, pwdata,    register access
//             prdata, pready
//
// Update: taken in S_IDLE, then the ack is loaded from S_SUM once the output is free.
// Purge: one table slot per cycle from the top, then the reports, one per cycle
// while the output is free, then the summary. List: the departed entries, then the summary.
// The cell row shifts down by one slot per cycle on a removal.
// Reset (rst, synchronous) empties both lists and sets the stale limit to 6000.
// A stalled output holds the sequencer; the next item is taken once the
// summary or ack sits in the output register.
`default_nettype none
module peer_table_with_aging_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pta_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pta_pkg::out_t        out_data,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pta_pkg::*;

  localparam int LW = $clog2(PEER_DEPTH + 1);
  localparam int LI = $clog2(PEER_DEPTH);
  localparam int GW = $clog2(GONE_DEPTH + 1);
  localparam int GI = $clog2(GONE_DEPTH);
  localparam int RW = $clog2(MAX_REPORT + 1);
  localparam int RI = (MAX_REPORT > 1) ? $clog2(MAX_REPORT) : 1;
  localparam int TW = POWER_W + LW;
  localparam int XW = (TW > TOTAL_W) ? TW : TOTAL_W;

  typedef enum logic [2:0] {S_IDLE, S_PURGE, S_RPT, S_LIST, S_SUM} state_t;

  state_t            state;
  logic [TIME_W-1:0] stale_limit;
  logic [TIME_W-1:0] req_now;
  logic [LW-1:0]     live_len;
  logic [GW-1:0]     gone_len;
  logic [TW-1:0]     total;
  logic [LW-1:0]     ptr;
  logic [RW-1:0]     rpt_cnt;
  logic [RW-1:0]     rpt_idx;
  logic [GW-1:0]     list_idx;
  logic [1:0]        sum_kind;
  logic              sum_drop;
  logic [MAC_W-1:0]  rpt_mac [MAX_REPORT];
  logic [PRIO_W-1:0] rpt_prio [MAX_REPORT];
  logic [MAX_REPORT-1:0] rpt_drop;

  live_ent_t             live_ent [PEER_DEPTH];
  logic [PEER_DEPTH-1:0] live_match, live_stale, live_hit, live_load, live_shift;
  gone_ent_t             gone_ent [GONE_DEPTH];
  logic [GONE_DEPTH-1:0] gone_match, gone_hit, gone_above, gone_load, gone_shift;

  logic               in_fire, upd, out_free, any_hit, full, any_g, gone_full;
  logic [POWER_W-1:0] old_power;
  logic               busy, rm, rm_report;
  logic [LW-1:0]      ptr_m1;
  logic [LI-1:0]      pj;
  live_ent_t          new_ent;
  gone_ent_t          rm_gone;
  logic [XW-1:0]      total_x;
  logic [TOTAL_W-1:0] total_sat;
  logic               acc;
  logic               res_load;

  assign in_ready = state == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign upd      = in_fire && in_data.op == OP_UPDATE;
  assign out_free = !out_valid || out_ready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_STALE) ? stale_limit : 32'd0;

  // a result enters the output register this cycle
  assign res_load = out_free && ((state == S_RPT && rpt_idx != rpt_cnt) ||
                                 (state == S_LIST && list_idx != gone_len) ||
                                 state == S_SUM);

  assign new_ent = '{mac: in_data.peer_mac, power: in_data.peer_power,
                     prio: in_data.peer_priority, seen: in_data.now_ms};

  // update lookup
  always_comb begin
    old_power = '0;
    for (int i = 0; i < PEER_DEPTH; i++) begin
      live_hit[i] = live_match[i] && (LW'(i) < live_len);
      if (live_hit[i]) old_power = old_power | live_ent[i].power;
    end
  end
  assign any_hit = |live_hit;
  assign full    = live_len == LW'(PEER_DEPTH);

  // departed removal: nearest the end wins, everything from it up shifts
  always_comb begin
    acc = 1'b0;
    for (int i = GONE_DEPTH - 1; i >= 0; i--) begin
      gone_hit[i]   = gone_match[i] && (GW'(i) < gone_len);
      gone_above[i] = acc;
      acc           = acc | gone_hit[i];
    end
  end
  assign any_g     = |gone_hit;
  assign gone_full = gone_len == GW'(GONE_DEPTH);

  // purge scan
  assign busy      = state == S_PURGE && ptr != '0;
  assign ptr_m1    = ptr - 1'b1;
  assign pj        = ptr_m1[LI-1:0];
  assign rm        = busy && live_stale[pj];
  assign rm_report = rm && rpt_cnt < RW'(MAX_REPORT);
  assign rm_gone   = '{mac: live_ent[pj].mac, prio: live_ent[pj].prio};

  always_comb begin
    for (int i = 0; i < PEER_DEPTH; i++) begin
      live_load[i]  = upd && (live_hit[i] || (!any_hit && !full && LW'(i) == live_len));
      live_shift[i] = rm && (LI'(i) >= pj);
    end
    for (int i = 0; i < GONE_DEPTH; i++) begin
      gone_shift[i] = upd && any_g && !gone_above[i];
      gone_load[i]  = rm_report && !gone_full && GW'(i) == gone_len;
    end
  end

  for (genvar i = 0; i < PEER_DEPTH; i++) begin : g_live
    live_ent_t up;
    if (i == PEER_DEPTH - 1) begin : g_top
      assign up = live_ent[i];
    end else begin : g_mid
      assign up = live_ent[i+1];
    end
    pta_live_cell u_cell (
      .clk(clk), .load(live_load[i]), .load_ent(new_ent), .shift(live_shift[i]),
      .upper_ent(up), .key(in_data.peer_mac), .now_ms(req_now),
      .limit(stale_limit), .ent(live_ent[i]), .match(live_match[i]),
      .stale(live_stale[i])
    );
  end

  for (genvar i = 0; i < GONE_DEPTH; i++) begin : g_gone
    gone_ent_t up;
    if (i == GONE_DEPTH - 1) begin : g_top
      assign up = gone_ent[i];
    end else begin : g_mid
      assign up = gone_ent[i+1];
    end
    pta_gone_cell u_cell (
      .clk(clk), .load(gone_load[i]), .load_ent(rm_gone), .shift(gone_shift[i]),
      .upper_ent(up), .key(in_data.peer_mac), .ent(gone_ent[i]),
      .match(gone_match[i])
    );
  end

  assign total_x   = XW'(total);
  assign total_sat = (total_x > XW'(POWER_MAX)) ? POWER_MAX : TOTAL_W'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stale_limit <= STALE_RESET;
      live_len    <= '0;
      gone_len    <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
      ptr         <= '0;
      rpt_cnt     <= '0;
      rpt_idx     <= '0;
      list_idx    <= '0;
      sum_kind    <= KIND_END;
      sum_drop    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == ADDR_STALE) begin
        stale_limit <= pwdata;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_now <= in_data.now_ms;
            unique case (in_data.op)
              OP_UPDATE: begin
                if (any_hit) begin
                  total <= total - TW'(old_power) + TW'(in_data.peer_power);
                end else if (!full) begin
                  total    <= total + TW'(in_data.peer_power);
                  live_len <= live_len + 1'b1;
                end
                if (any_g) gone_len <= gone_len - 1'b1;
                sum_kind <= KIND_ACK;
                sum_drop <= !any_hit && full;
                state    <= S_SUM;
              end
              OP_PURGE: begin
                ptr      <= live_len;
                rpt_cnt  <= '0;
                sum_kind <= KIND_END;
                sum_drop <= 1'b0;
                state    <= S_PURGE;
              end
              OP_LIST: begin
                list_idx <= '0;
                sum_kind <= KIND_END;
                sum_drop <= 1'b0;
                state    <= S_LIST;
              end
              default: begin
                sum_kind <= KIND_END;
                sum_drop <= 1'b0;
                state    <= S_SUM;
              end
            endcase
          end
        end
        S_PURGE: begin
          if (ptr == '0) begin
            rpt_idx <= '0;
            state   <= S_RPT;
          end else begin
            ptr <= ptr_m1;
            if (rm) begin
              live_len <= live_len - 1'b1;
              total    <= total - TW'(live_ent[pj].power);
            end
            if (rm_report) begin
              rpt_mac[rpt_cnt[RI-1:0]]  <= rm_gone.mac;
              rpt_prio[rpt_cnt[RI-1:0]] <= rm_gone.prio;
              rpt_drop[rpt_cnt[RI-1:0]] <= gone_full;
              rpt_cnt <= rpt_cnt + 1'b1;
              if (gone_full) begin
                sum_drop <= 1'b1;
              end else begin
                gone_len <= gone_len + 1'b1;
              end
            end
          end
        end
        S_RPT: begin
          if (rpt_idx == rpt_cnt) begin
            state <= S_SUM;
          end else if (out_free) begin
            out_data  <= '{kind: KIND_REMOVED, entry_mac: rpt_mac[rpt_idx[RI-1:0]],
                           entry_priority: rpt_prio[rpt_idx[RI-1:0]],
                           total_power: total_sat, live_count: COUNT_W'(live_len),
                           departed_count: COUNT_W'(gone_len),
                           dropped: rpt_drop[rpt_idx[RI-1:0]], last: 1'b0};
            rpt_idx   <= rpt_idx + 1'b1;
          end
        end
        S_LIST: begin
          if (list_idx == gone_len) begin
            state <= S_SUM;
          end else if (out_free) begin
            out_data  <= '{kind: KIND_GONE, entry_mac: gone_ent[list_idx[GI-1:0]].mac,
                           entry_priority: gone_ent[list_idx[GI-1:0]].prio,
                           total_power: total_sat, live_count: COUNT_W'(live_len),
                           departed_count: COUNT_W'(gone_len),
                           dropped: 1'b0, last: 1'b0};
            list_idx  <= list_idx + 1'b1;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_data  <= '{kind: sum_kind, entry_mac: '0, entry_priority: '0,
                           total_power: total_sat, live_count: COUNT_W'(live_len),
                           departed_count: COUNT_W'(gone_len),
                           dropped: sum_drop, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_ACK |-> out_data.last)
    else $error("ack without last");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    live_len <= LW'(PEER_DEPTH) && gone_len <= GW'(GONE_DEPTH))
    else $error("list length overflow");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second item before results");

  a_rpt_bound: assert property (@(posedge clk) disable iff (rst)
    rpt_cnt <= RW'(MAX_REPORT))
    else $error("report count overflow");

endmodule
`default_nettype wire

// File: hw/rtl/pta_live_cell.sv
// One table slot: holds a peer, matches its MAC and flags it stale.
`default_nettype none
module pta_live_cell (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire pta_pkg::live_ent_t         load_ent,
  input  wire logic                       shift,
  input  wire pta_pkg::live_ent_t         upper_ent,
  input  wire logic [pta_pkg::MAC_W-1:0]  key,
  input  wire logic [pta_pkg::TIME_W-1:0] now_ms,
  input  wire logic [pta_pkg::TIME_W-1:0] limit,
  output pta_pkg::live_ent_t              ent,
  output logic                            match,
  output logic                            stale
);
  import pta_pkg::*;

  logic [TIME_W-1:0] age;

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_ent;
    end else if (shift) begin
      ent <= upper_ent;
    end
  end

  // wrapping age
  assign age   = now_ms - ent.seen;
  assign stale = age > limit;
  assign match = ent.mac == key;

endmodule
`default_nettype wire

// File: hw/rtl/pta_gone_cell.sv
// One departed-list slot: holds MAC and priority, matches its MAC.
`default_nettype none
module pta_gone_cell (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire pta_pkg::gone_ent_t        load_ent,
  input  wire logic                      shift,
  input  wire pta_pkg::gone_ent_t        upper_ent,
  input  wire logic [pta_pkg::MAC_W-1:0] key,
  output pta_pkg::gone_ent_t             ent,
  output logic                           match
);
  import pta_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_ent;
    end else if (shift) begin
      ent <= upper_ent;
    end
  end

  assign match = ent.mac == key;

endmodule
`default_nettype wire
